### hdl/ohi_pkg.sv
// ----------------------------------------------------------------------------
// ohi_pkg: shared definitions for the open-address hash insert block
// Table geometry, field widths, register indexes, result codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package ohi_pkg;

    localparam int SLOTS     = 16;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int KEY_W     = 31;
    localparam int SIZE_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = SIZE_W;

    // Remainder unit retires two key bits per cycle
    localparam int DIV_STEPS = (KEY_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // tdata widths, rounded up to whole bytes
    localparam int S_DATA_BITS = KEY_W + IDX_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = IDX_W + KEY_W + CNT_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_KIND   = 1'd1;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic PROBE_LINEAR    = 1'b0;
    localparam logic PROBE_QUADRATIC = 1'b1;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_OCCUPIED = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PROBE,
        ST_READ
    } ohi_state_t;

endpackage

### hdl/ohi_ram.sv
// ----------------------------------------------------------------------------
// ohi_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ohi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/open_address_hash_insert_top.sv
// ----------------------------------------------------------------------------
// open_address_hash_insert_top: open-addressing hash table, insert and read
// Stores keys by linear or quadratic probing and returns single slot contents.
// ----------------------------------------------------------------------------
// One transaction at a time. An insert is accepted, then runs through the
// remainder unit (key mod size, two key bits a cycle), then probes the slot
// table one slot at a time until a free slot is found or n slots have been
// probed, n being the table size. A read is accepted and reads the key RAM.
// A finished result waits in the output register while the next transaction
// is accepted; a result only holds the sequencer if the previous one has not
// been taken yet. Valid marks are cleared at reset, so no clearing pass is
// needed. A size of 0 acts as 1 and a size above 16 acts as 16.
// ----------------------------------------------------------------------------
module open_address_hash_insert_top
    import ohi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,  // key, slot_index, zero fill
    input  logic                 s_axis_tuser,  // mode
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DATA_W-1:0]  m_axis_tdata,  // slot, stored_key, probe_count
    output logic [1:0]           m_axis_tuser   // status
);

    ohi_state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_reg;
    logic              kind_reg;
    logic [SLOTS-1:0]  valid_reg, valid_next;

    logic [KEY_W-1:0]  key_reg, key_next;
    logic [IDX_W-1:0]  sidx_reg, sidx_next;
    logic [DIV_W-1:0]  div_sh_reg, div_sh_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  delta_reg, delta_next;
    logic [CNT_W-1:0]  probe_reg, probe_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [IDX_W-1:0]  m_slot_reg, m_slot_next;
    logic [KEY_W-1:0]  m_key_reg, m_key_next;
    logic [CNT_W-1:0]  m_probes_reg, m_probes_next;

    logic [CNT_W-1:0]  n;
    logic              out_free;
    logic [KEY_W-1:0]  in_key;
    logic [IDX_W-1:0]  in_sidx;

    logic [SUM_W-1:0]  r1_t, r2_t;
    logic [IDX_W-1:0]  r1, r2;
    logic [SUM_W-1:0]  idx_sum, dlt_sum;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [KEY_W-1:0]  ram_rd_data;

    // effective table size
    always_comb begin
        if (size_reg == '0) begin
            n = CNT_W'(1);
        end else if (SUM_W'(size_reg) > SUM_W'(SLOTS)) begin
            n = CNT_W'(SLOTS);
        end else begin
            n = CNT_W'(size_reg);
        end
    end

    assign in_key  = s_axis_tdata[KEY_W-1:0];
    assign in_sidx = s_axis_tdata[KEY_W +: IDX_W];

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = M_DATA_W'({m_probes_reg, m_key_reg, m_slot_reg});

    // two restoring remainder steps per cycle
    always_comb begin
        r1_t = {1'b0, rem_reg, div_sh_reg[DIV_W-1]};
        if (r1_t >= SUM_W'(n)) begin
            r1_t = r1_t - SUM_W'(n);
        end
        r1   = r1_t[IDX_W-1:0];
        r2_t = {1'b0, r1, div_sh_reg[DIV_W-2]};
        if (r2_t >= SUM_W'(n)) begin
            r2_t = r2_t - SUM_W'(n);
        end
        r2   = r2_t[IDX_W-1:0];
    end

    // next probe index and next quadratic step, both reduced mod n
    always_comb begin
        idx_sum = SUM_W'(idx_reg) + SUM_W'(delta_reg);
        if (idx_sum >= SUM_W'(n)) begin
            idx_sum = idx_sum - SUM_W'(n);
        end
        dlt_sum = SUM_W'(delta_reg) + SUM_W'(2);
        if (dlt_sum >= SUM_W'(n)) begin
            dlt_sum = dlt_sum - SUM_W'(n);
        end
        if (dlt_sum >= SUM_W'(n)) begin
            dlt_sum = dlt_sum - SUM_W'(n);
        end
    end

    assign ram_rd_addr = (state_reg == ST_IDLE) ? in_sidx : sidx_reg;

    ohi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (key_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        key_next      = key_reg;
        sidx_next     = sidx_reg;
        div_sh_next   = div_sh_reg;
        div_cnt_next  = div_cnt_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        delta_next    = delta_reg;
        probe_next    = probe_reg;
        ram_we        = 1'b0;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_key_next    = m_key_reg;
        m_probes_next = m_probes_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    key_next     = in_key;
                    sidx_next    = in_sidx;
                    div_sh_next  = DIV_W'(in_key);
                    div_cnt_next = '0;
                    rem_next     = '0;
                    state_next   = (s_axis_tuser == MODE_READ) ? ST_READ : ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next     = r2;
                div_sh_next  = div_sh_reg << 2;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    idx_next   = r2;
                    probe_next = '0;
                    delta_next = (n == CNT_W'(1)) ? '0 : IDX_W'(1);
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!valid_reg[idx_reg]) begin
                    // hold until the previous result is taken
                    if (out_free) begin
                        ram_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        m_valid_next        = 1'b1;
                        m_status_next       = STAT_INSERTED;
                        m_slot_next         = idx_reg;
                        m_key_next          = key_reg;
                        m_probes_next       = probe_reg;
                        state_next          = ST_IDLE;
                    end
                end else if (probe_reg == n - 1'b1) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_FULL;
                        m_slot_next   = '0;
                        m_key_next    = '0;
                        m_probes_next = n;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    probe_next = probe_reg + 1'b1;
                    idx_next   = idx_sum[IDX_W-1:0];
                    if (kind_reg == PROBE_QUADRATIC) begin
                        delta_next = dlt_sum[IDX_W-1:0];
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = sidx_reg;
                    m_probes_next = '0;
                    if (SUM_W'(sidx_reg) < SUM_W'(n) && valid_reg[sidx_reg]) begin
                        m_status_next = STAT_OCCUPIED;
                        m_key_next    = ram_rd_data;
                    end else begin
                        m_status_next = STAT_EMPTY;
                        m_key_next    = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(10);
            kind_reg <= PROBE_QUADRATIC;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SLOTS_IN_USE: size_reg <= cfg_wdata[SIZE_W-1:0];
                REG_PROBE_KIND:   kind_reg <= cfg_wdata[0];
                default: begin
                    size_reg <= size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        sidx_reg     <= sidx_next;
        div_sh_reg   <= div_sh_next;
        div_cnt_reg  <= div_cnt_next;
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        delta_reg    <= delta_next;
        probe_reg    <= probe_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_key_reg    <= m_key_next;
        m_probes_reg <= m_probes_next;
    end

endmodule
